>>> design/spmv_pkg.sv
`timescale 1ns / 1ps
// Package: shared constants, codes, request/response and control types for the spmv unit
package spmv_pkg;

    localparam int VECTOR_DEPTH = 1024;
    localparam int VEC_AW       = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;
    localparam int RESULT_DEPTH = 1024;
    localparam int RES_AW       = $clog2(RESULT_DEPTH);
    localparam int IDX_W        = 10;
    localparam int VAL_W        = 32;
    localparam int SUM_W        = 64;
    localparam int ENTRY_W      = SUM_W + 1;

    // function codes of a request
    localparam logic [2:0] FN_LOAD    = 3'd0;
    localparam logic [2:0] FN_ENTRY   = 3'd1;
    localparam logic [2:0] FN_ROW_END = 3'd2;
    localparam logic [2:0] FN_READ    = 3'd3;
    localparam logic [2:0] FN_START   = 3'd4;

    typedef struct packed {
        logic [2:0]              func;
        logic [IDX_W-1:0]        index;
        logic signed [VAL_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic [IDX_W-1:0]        result_index;
        logic signed [SUM_W-1:0] sum;
        logic                    saturated;
    } t_rsp;

    // one scatter store word
    typedef struct packed {
        logic                    saturated;
        logic signed [SUM_W-1:0] sum;
    } t_entry;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic load_wr;
        logic mul;
        logic acc;
        logic row_end;
        logic start_clr;
        logic rd_out;
        logic clr_step;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [2:0] func;
        logic       clr_last;
    } t_sts;

endpackage

>>> design/spmv_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port
module spmv_ram #(
    parameter int  WIDTH = 32,
    parameter int  DEPTH = 1024,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/spmv_ctrl.sv
`timescale 1ns / 1ps
// Controller: one-hot state machine sequencing each request through the datapath
module spmv_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  spmv_pkg::t_sts  i_sts,
    output spmv_pkg::t_cmd  o_cmd,
    output logic            o_busy
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_EXEC  = 6'b000010,
        S_MUL   = 6'b000100,
        S_ACC   = 6'b001000,
        S_RDOUT = 6'b010000,
        S_CLEAR = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                case (i_sts.func)
                    spmv_pkg::FN_LOAD: begin
                        o_cmd.load_wr = 1'b1;
                        n_state       = S_IDLE;
                    end
                    spmv_pkg::FN_ENTRY: begin
                        n_state = S_MUL;
                    end
                    spmv_pkg::FN_ROW_END: begin
                        o_cmd.row_end = 1'b1;
                        n_state       = S_IDLE;
                    end
                    spmv_pkg::FN_READ: begin
                        n_state = S_RDOUT;
                    end
                    spmv_pkg::FN_START: begin
                        o_cmd.start_clr = 1'b1;
                        n_state         = S_CLEAR;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = S_IDLE;
            end
            S_RDOUT: begin
                o_cmd.rd_out = 1'b1;
                n_state      = S_IDLE;
            end
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

>>> design/spmv_dp.sv
`timescale 1ns / 1ps
// Datapath: vector and scatter stores, multiplier, saturating accumulator, result register
module spmv_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic           i_cfg_wdata,
    input  spmv_pkg::t_req i_req,
    input  spmv_pkg::t_cmd i_cmd,
    output spmv_pkg::t_sts o_sts,
    output logic           o_valid,
    output spmv_pkg::t_rsp o_rsp
);

    localparam int VAW = spmv_pkg::VEC_AW;
    localparam int IW  = spmv_pkg::IDX_W;
    localparam int SW  = spmv_pkg::SUM_W;

    spmv_pkg::t_req               r_req;
    logic                         r_mode;
    logic [IW-1:0]                r_row;
    logic signed [SW-1:0]         r_acc;
    logic                         r_sat;
    logic signed [SW-1:0]         r_prod;
    logic [spmv_pkg::RES_AW-1:0]  r_clr_addr;
    logic                         r_valid;
    spmv_pkg::t_rsp               r_rsp;

    logic [VAW+IW-1:0]            w_idx_ext;
    logic [VAW+IW-1:0]            w_row_ext;
    logic                         w_idx_ok;
    logic                         w_row_ok;
    logic                         w_vec_ok;
    logic [VAW-1:0]               w_vec_raddr;
    logic [spmv_pkg::VAL_W-1:0]   w_vec_rdata;
    logic signed [spmv_pkg::VAL_W-1:0] w_vec;
    logic signed [SW-1:0]         n_prod;

    spmv_pkg::t_entry             w_scat_rdata;
    spmv_pkg::t_entry             w_scat_wdata;
    logic                         w_scat_we;
    logic [spmv_pkg::RES_AW-1:0]  w_scat_waddr;

    logic signed [SW-1:0]         w_base;
    logic                         w_base_sat;
    logic [SW:0]                  w_sum_wide;
    logic                         w_ovf;
    logic signed [SW-1:0]         w_sum;
    logic                         w_sum_sat;

    // vector addresses; the store may be shallower or deeper than the index range
    assign w_idx_ext   = {{VAW{1'b0}}, r_req.index};
    assign w_row_ext   = {{VAW{1'b0}}, r_row};
    assign w_idx_ok    = {22'd0, r_req.index} < 32'(spmv_pkg::VECTOR_DEPTH);
    assign w_row_ok    = {22'd0, r_row} < 32'(spmv_pkg::VECTOR_DEPTH);
    assign w_vec_ok    = r_mode ? w_row_ok : w_idx_ok;
    assign w_vec_raddr = r_mode ? w_row_ext[VAW-1:0] : w_idx_ext[VAW-1:0];

    spmv_ram #(
        .WIDTH (spmv_pkg::VAL_W),
        .DEPTH (spmv_pkg::VECTOR_DEPTH)
    ) u_vec_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load_wr && w_idx_ok),
        .i_waddr (w_idx_ext[VAW-1:0]),
        .i_wdata (r_req.value),
        .i_raddr (w_vec_raddr),
        .o_rdata (w_vec_rdata)
    );

    // scatter store write port: clearing sweep, read-and-clear, or scatter update
    always_comb begin
        w_scat_we    = 1'b0;
        w_scat_waddr = r_req.index;
        w_scat_wdata = '0;
        if (i_cmd.clr_step) begin
            w_scat_we    = 1'b1;
            w_scat_waddr = r_clr_addr;
        end else if (i_cmd.rd_out) begin
            w_scat_we    = 1'b1;
        end else if (i_cmd.acc && r_mode) begin
            w_scat_we              = 1'b1;
            w_scat_wdata.sum       = w_sum;
            w_scat_wdata.saturated = w_sum_sat;
        end
    end

    spmv_ram #(
        .WIDTH (spmv_pkg::ENTRY_W),
        .DEPTH (spmv_pkg::RESULT_DEPTH)
    ) u_scat_ram (
        .i_clk   (i_clk),
        .i_we    (w_scat_we),
        .i_waddr (w_scat_waddr),
        .i_wdata (w_scat_wdata),
        .i_raddr (r_req.index),
        .o_rdata (w_scat_rdata)
    );

    // out-of-range vector operand reads as zero
    assign w_vec  = w_vec_ok ? w_vec_rdata : '0;
    assign n_prod = SW'(r_req.value) * SW'(w_vec);

    // saturating accumulate
    assign w_base     = r_mode ? w_scat_rdata.sum : r_acc;
    assign w_base_sat = r_mode ? w_scat_rdata.saturated : r_sat;
    assign w_sum_wide = {w_base[SW-1], w_base} + {r_prod[SW-1], r_prod};
    assign w_ovf      = w_sum_wide[SW] != w_sum_wide[SW-1];
    assign w_sum      = !w_ovf ? w_sum_wide[SW-1:0] :
                        (w_sum_wide[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}});
    assign w_sum_sat  = w_base_sat | w_ovf;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= i_req;
        end
        if (i_cmd.mul) begin
            r_prod <= n_prod;
        end
        if (i_cmd.row_end) begin
            r_rsp.result_index <= r_row;
            r_rsp.sum          <= r_acc;
            r_rsp.saturated    <= r_sat;
        end else if (i_cmd.rd_out) begin
            r_rsp.result_index <= r_req.index;
            r_rsp.sum          <= w_scat_rdata.sum;
            r_rsp.saturated    <= w_scat_rdata.saturated;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= 1'b0;
            r_row      <= '0;
            r_acc      <= '0;
            r_sat      <= 1'b0;
            r_clr_addr <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_valid <= (i_cmd.row_end && !r_mode) || i_cmd.rd_out;
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            if (i_cmd.clr_step) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cmd.start_clr) begin
                r_row <= '0;
                r_acc <= '0;
                r_sat <= 1'b0;
            end else if (i_cmd.row_end) begin
                r_row <= r_row + 1'b1;
                r_acc <= '0;
                r_sat <= 1'b0;
            end else if (i_cmd.acc && !r_mode) begin
                r_acc <= w_sum;
                r_sat <= w_sum_sat;
            end
        end
    end

    assign o_sts.func     = r_req.func;
    assign o_sts.clr_last = r_clr_addr == spmv_pkg::RES_AW'(spmv_pkg::RESULT_DEPTH - 1);
    assign o_valid        = r_valid;
    assign o_rsp          = r_rsp;

endmodule

>>> design/csr_sparse_matrix_vector_multiply_unit.sv
`timescale 1ns / 1ps
// Top level of the csr sparse matrix vector multiply unit: controller and datapath
// Results: a row end with r_mode low registers its result in EXEC, a read in RDOUT.
// Sequencing: one request at a time; load, row end and unused codes pass IDLE, EXEC;
// a matrix entry also MUL and ACC (fetch, registered 32x32 multiply, saturating add and
// write-back), a read RDOUT, and start CLEAR for the scatter store sweep of 1024 entries.
// Reset: synchronous active low; busy stays high for the clearing sweep of 1024 entries.
module csr_sparse_matrix_vector_multiply_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  spmv_pkg::t_req i_req,
    input  logic           i_cfg_we,
    input  logic           i_cfg_wdata,
    output logic           o_valid,
    output spmv_pkg::t_rsp o_rsp
);

    spmv_pkg::t_cmd w_cmd;
    spmv_pkg::t_sts w_sts;

    spmv_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    spmv_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (i_req),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_valid     (o_valid),
        .o_rsp       (o_rsp)
    );

endmodule

>>> design/spmv_chk.sv
`timescale 1ns / 1ps
// Checker: port-level timing properties of the spmv unit, bound to the top level
module spmv_chk (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           start,
    input logic           busy,
    input spmv_pkg::t_req i_req,
    input logic           o_valid
);

    // reset always begins a clearing sweep
    a_reset_busy: assert property (@(posedge i_clk) !i_rst_n |=> busy)
        else $error("not busy after reset");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("not busy after an accepted request");

    a_valid_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result strobe without a request in progress");

    a_valid_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held longer than one cycle");

    // a read request always answers with a result strobe
    a_read_answers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_req.func == spmv_pkg::FN_READ) |-> ##3 o_valid)
        else $error("read request gave no result");

endmodule

bind csr_sparse_matrix_vector_multiply_unit spmv_chk u_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .i_req   (i_req),
    .o_valid (o_valid)
);
